// ----- sv/ntcf_pkg.sv -----
// shared types and constants for the nearest target cooldown finder
`timescale 1ns / 1ps

package ntcf_pkg;

  // slot table size and derived widths
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int TIME_W     = 16;
  localparam int DIFF_W     = 16;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int POS_W      = 2 * COORD_W;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // cooldown after reset
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 16'd1000;

  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [IDX_W-1:0]          tidx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // status of the scan unit towards the control
  typedef struct packed {
    logic   done;
    logic   found;
    slot_t  idx;
    coord_t x;
    coord_t y;
  } scan_stat_t;

  // one result item
  typedef struct packed {
    logic   fire;
    tidx_t  target_index;
    coord_t target_x;
    coord_t target_y;
  } result_t;

endpackage

// ----- sv/nearest_target_cooldown_finder_unit.sv -----
// top level: slot table, shot timer, search control and result register
//
//  channel | ports                                         | dir | transfer when
//  --------+-----------------------------------------------+-----+---------------------
//  in      | in_valid in_stall in_kind in_slot_* in_player_* | in  | in_valid & !in_stall
//          | in_elapsed                                    |     |
//  out     | out_valid out_stall out_fire out_target_*     | out | out_valid & !out_stall
//  cfg     | cfg_valid cfg_ready cfg_cooldown              | in  | cfg_valid & cfg_ready
//
// a write item or a tick without search passes the result stage into the output register;
// a searching tick reads one slot per cycle from the position memory, and its result goes
// the same way once the last slot has left the scan pipeline; in both cases the next input
// is taken once the sequencer is back in idle
// reset clears the active flags and the timer and loads the cooldown with 1000, no sweep
// while the output is stalled one more item is taken and waits in the result stage
`timescale 1ns / 1ps

module nearest_target_cooldown_finder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [5:0]           in_slot_index,
  input  logic                 in_slot_active,
  input  logic signed [15:0]   in_slot_x,
  input  logic signed [15:0]   in_slot_y,
  input  logic signed [15:0]   in_player_x,
  input  logic signed [15:0]   in_player_y,
  input  logic [15:0]          in_elapsed,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_fire,
  output logic [5:0]           out_target_index,
  output logic signed [15:0]   out_target_x,
  output logic signed [15:0]   out_target_y,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_cooldown
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state_r;
  logic [1:0]                     state_nxt;
  logic [ntcf_pkg::TIME_W-1:0]    timer_r;
  logic [ntcf_pkg::TIME_W-1:0]    timer_nxt;
  logic [ntcf_pkg::TIME_W-1:0]    cooldown_r;
  logic [ntcf_pkg::SLOT_COUNT-1:0] active_r;
  ntcf_pkg::result_t              res_r;
  ntcf_pkg::result_t              out_res_r;
  logic                           out_valid_r;

  logic                           in_acc;
  logic                           out_free;
  logic [ntcf_pkg::TIME_W:0]      timer_sum;
  logic [ntcf_pkg::TIME_W-1:0]    timer_sat;
  logic                           do_search;
  logic                           scan_start;
  logic                           slot_ok;
  logic                           slot_we;
  ntcf_pkg::slot_t                slot_addr;
  ntcf_pkg::slot_t                rd_addr;
  ntcf_pkg::pos_t                 rd_data;
  ntcf_pkg::scan_stat_t           scan_st;
  ntcf_pkg::result_t              scan_res;

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // saturating timer add and search decision
  assign timer_sum  = {1'b0, timer_r} + {1'b0, in_elapsed};
  assign timer_sat  = timer_sum[ntcf_pkg::TIME_W] ? '1 : timer_sum[ntcf_pkg::TIME_W-1:0];
  assign do_search  = (timer_sat >= cooldown_r);
  assign scan_start = in_acc && (in_kind == ntcf_pkg::KIND_TICK) && do_search;

  // slot write decode
  assign slot_ok   = (32'(in_slot_index) < ntcf_pkg::SLOT_COUNT);
  assign slot_we   = in_acc && (in_kind == ntcf_pkg::KIND_WRITE) && slot_ok;
  assign slot_addr = ntcf_pkg::slot_t'(in_slot_index);

  // position memory, x in the upper half
  ntcf_ram #(
    .WIDTH (ntcf_pkg::POS_W),
    .DEPTH (ntcf_pkg::SLOT_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata ({in_slot_x, in_slot_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ntcf_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .player_x (in_player_x),
    .player_y (in_player_y),
    .active   (active_r),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .stat     (scan_st)
  );

  // active flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (slot_we) begin
      active_r[slot_addr] <= in_slot_active;
    end
  end

  // cooldown register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= ntcf_pkg::COOLDOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cooldown_r <= cfg_cooldown;
    end
  end

  // scan result, zero when nothing was found
  always_comb begin
    scan_res = '0;
    if (scan_st.found) begin
      scan_res.fire         = 1'b1;
      scan_res.target_index = ntcf_pkg::tidx_t'(scan_st.idx);
      scan_res.target_x     = scan_st.x;
      scan_res.target_y     = scan_st.y;
    end
  end

  // control sequencer and timer
  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == ntcf_pkg::KIND_TICK) begin
            timer_nxt = timer_sat;
          end
          state_nxt = scan_start ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_st.done) begin
          if (scan_st.found) begin
            timer_nxt = '0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= '0;
    end else begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      res_r <= '0;
    end else if (state_r == ST_SCAN && scan_st.done) begin
      res_r <= scan_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fire         = out_res_r.fire;
  assign out_target_index = out_res_r.target_index;
  assign out_target_x     = out_res_r.target_x;
  assign out_target_y     = out_res_r.target_y;

  // scan completion only while the sequencer waits for it
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> (state_r == ST_SCAN))
    else $error("scan finished outside of a search");

  // a fired search leaves the timer cleared
  a_fire_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_st.done && scan_st.found) |=> (timer_r == '0))
    else $error("timer not cleared after fire");

  // a search only ends in the result stage
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (state_r == ST_SCAN || state_r == ST_DONE))
    else $error("search left to an unexpected state");

endmodule

// ----- sv/ntcf_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ntcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ntcf_scan.sv -----
// scan unit: walks the position memory and keeps the nearest active slot
`timescale 1ns / 1ps

module ntcf_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  ntcf_pkg::coord_t                   player_x,
  input  ntcf_pkg::coord_t                   player_y,
  input  logic [ntcf_pkg::SLOT_COUNT-1:0]    active,
  output ntcf_pkg::slot_t                    rd_addr,
  input  ntcf_pkg::pos_t                     rd_data,
  output ntcf_pkg::scan_stat_t               stat
);

  // address issue
  logic              issue_r;
  ntcf_pkg::slot_t   cnt_r;
  ntcf_pkg::coord_t  px_r;
  ntcf_pkg::coord_t  py_r;
  logic              last_issue;

  // stage 1: memory read in flight
  logic              s1_valid_r;
  logic              s1_last_r;
  logic              s1_act_r;
  ntcf_pkg::slot_t   s1_idx_r;

  // stage 2: absolute differences
  logic                        s2_valid_r;
  logic                        s2_last_r;
  logic                        s2_act_r;
  ntcf_pkg::slot_t             s2_idx_r;
  ntcf_pkg::coord_t            s2_x_r;
  ntcf_pkg::coord_t            s2_y_r;
  logic [ntcf_pkg::DIFF_W-1:0] s2_dx_r;
  logic [ntcf_pkg::DIFF_W-1:0] s2_dy_r;

  // stage 3: squares
  logic                      s3_valid_r;
  logic                      s3_last_r;
  logic                      s3_act_r;
  ntcf_pkg::slot_t           s3_idx_r;
  ntcf_pkg::coord_t          s3_x_r;
  ntcf_pkg::coord_t          s3_y_r;
  logic [ntcf_pkg::SQ_W-1:0] s3_sqx_r;
  logic [ntcf_pkg::SQ_W-1:0] s3_sqy_r;

  // best so far
  logic              best_found_r;
  ntcf_pkg::dist_t   best_dist_r;
  ntcf_pkg::slot_t   best_idx_r;
  ntcf_pkg::coord_t  best_x_r;
  ntcf_pkg::coord_t  best_y_r;
  logic              done_r;

  logic signed [ntcf_pkg::COORD_W:0] diff_x;
  logic signed [ntcf_pkg::COORD_W:0] diff_y;
  logic [ntcf_pkg::COORD_W:0]        abs_x;
  logic [ntcf_pkg::COORD_W:0]        abs_y;
  ntcf_pkg::coord_t                  mem_x;
  ntcf_pkg::coord_t                  mem_y;
  ntcf_pkg::dist_t                   sq_dist;
  logic                              take;

  assign last_issue = (cnt_r == ntcf_pkg::slot_t'(ntcf_pkg::SLOT_COUNT - 1));
  assign rd_addr    = cnt_r;

  // issue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      issue_r <= 1'b1;
      cnt_r   <= '0;
    end else if (issue_r) begin
      issue_r <= !last_issue;
      cnt_r   <= last_issue ? '0 : cnt_r + 1'b1;
    end
  end

  // player position held for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= player_x;
      py_r <= player_y;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // absolute differences against the player, 17 bit signed then magnitude
  assign mem_x  = rd_data[ntcf_pkg::POS_W-1:ntcf_pkg::COORD_W];
  assign mem_y  = rd_data[ntcf_pkg::COORD_W-1:0];
  assign diff_x = {mem_x[ntcf_pkg::COORD_W-1], mem_x} - {px_r[ntcf_pkg::COORD_W-1], px_r};
  assign diff_y = {mem_y[ntcf_pkg::COORD_W-1], mem_y} - {py_r[ntcf_pkg::COORD_W-1], py_r};
  assign abs_x  = diff_x[ntcf_pkg::COORD_W] ? -diff_x : diff_x;
  assign abs_y  = diff_y[ntcf_pkg::COORD_W] ? -diff_y : diff_y;

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_last_r <= last_issue;
    s1_act_r  <= active[cnt_r];
    s1_idx_r  <= cnt_r;

    s2_last_r <= s1_last_r;
    s2_act_r  <= s1_act_r;
    s2_idx_r  <= s1_idx_r;
    s2_x_r    <= mem_x;
    s2_y_r    <= mem_y;
    s2_dx_r   <= abs_x[ntcf_pkg::DIFF_W-1:0];
    s2_dy_r   <= abs_y[ntcf_pkg::DIFF_W-1:0];

    s3_last_r <= s2_last_r;
    s3_act_r  <= s2_act_r;
    s3_idx_r  <= s2_idx_r;
    s3_x_r    <= s2_x_r;
    s3_y_r    <= s2_y_r;
    s3_sqx_r  <= s2_dx_r * s2_dx_r;
    s3_sqy_r  <= s2_dy_r * s2_dy_r;
  end

  // distance and compare, strict less keeps the lowest index on a tie
  assign sq_dist = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
  assign take = s3_valid_r && s3_act_r && (!best_found_r || (sq_dist < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      done_r <= s3_valid_r && s3_last_r;
      if (start) begin
        best_found_r <= 1'b0;
      end else if (take) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist_r <= sq_dist;
      best_idx_r  <= s3_idx_r;
      best_x_r    <= s3_x_r;
      best_y_r    <= s3_y_r;
    end
  end

  assign stat.done  = done_r;
  assign stat.found = best_found_r;
  assign stat.idx   = best_idx_r;
  assign stat.x     = best_x_r;
  assign stat.y     = best_y_r;

endmodule

// ----- test/tb_nearest_target_cooldown_finder_unit.sv -----
// testbench for the nearest target cooldown finder: directed and random items, shot scoreboard
`timescale 1ns / 1ps

module tb_nearest_target_cooldown_finder_unit;
  import ntcf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 6;

  // one input transfer as the driver sees it
  typedef struct {
    logic        kind;
    logic [5:0]  slot;
    logic        active;
    coord_t      slot_x;
    coord_t      slot_y;
    coord_t      player_x;
    coord_t      player_y;
    logic [15:0] elapsed;
  } finder_item_t;

  // predicts the shot for each item and holds the shots still owed by the block
  class shot_scoreboard;
    logic [15:0] cooldown;
    logic [15:0] shot_timer;
    bit          slot_on [SLOT_COUNT];
    coord_t      slot_x [SLOT_COUNT];
    coord_t      slot_y [SLOT_COUNT];
    result_t     expected_shots [$];
    int          n_items;
    int          n_ticks;
    int          n_fires;
    int          n_results;
    int          n_errors;

    function new();
      cooldown   = COOLDOWN_RESET;
      shot_timer = '0;
      foreach (slot_on[i]) begin
        slot_on[i] = 1'b0;
        slot_x[i]  = '0;
        slot_y[i]  = '0;
      end
      n_items = 0;
      n_ticks = 0;
      n_fires = 0;
      n_results = 0;
      n_errors = 0;
    endfunction

    function void set_cooldown(logic [15:0] value);
      cooldown = value;
    endfunction

    function int pending();
      return expected_shots.size();
    endfunction

    // update the slot table or run the timed search
    function void take_item(finder_item_t it);
      result_t     shot;
      logic [16:0] sum;
      bit          found;
      longint      best;
      longint      sq_dist;
      longint      dx;
      longint      dy;
      int          best_slot;
      shot = '0;
      n_items++;
      if (it.kind == KIND_WRITE) begin
        if (it.slot < SLOT_COUNT) begin
          slot_on[it.slot] = it.active;
          slot_x[it.slot]  = it.slot_x;
          slot_y[it.slot]  = it.slot_y;
        end
      end else begin
        n_ticks++;
        sum = {1'b0, shot_timer} + {1'b0, it.elapsed};
        shot_timer = sum[16] ? 16'hffff : sum[15:0];
        if (shot_timer >= cooldown) begin
          found = 1'b0;
          best = 0;
          best_slot = 0;
          // exact squared distance, lowest slot wins a tie
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_on[i]) begin
              dx = longint'(slot_x[i]) - longint'(it.player_x);
              dy = longint'(slot_y[i]) - longint'(it.player_y);
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              sq_dist = dx * dx + dy * dy;
              if (!found || sq_dist < best) begin
                found = 1'b1;
                best = sq_dist;
                best_slot = i;
              end
            end
          end
          if (found) begin
            shot.fire         = 1'b1;
            shot.target_index = tidx_t'(best_slot);
            shot.target_x     = slot_x[best_slot];
            shot.target_y     = slot_y[best_slot];
            shot_timer        = '0;
            n_fires++;
          end
        end
      end
      expected_shots.push_back(shot);
    endfunction

    // compare one result transfer with the oldest predicted shot
    function void check_shot(result_t got);
      result_t want;
      n_results++;
      if (expected_shots.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: fire=%0d idx=%0d x=%0d y=%0d",
                   got.fire, got.target_index, got.target_x, got.target_y);
        return;
      end
      want = expected_shots.pop_front();
      if (got.fire !== want.fire || got.target_index !== want.target_index ||
          got.target_x !== want.target_x || got.target_y !== want.target_y) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch on result %0d: expected fire=%0d idx=%0d x=%0d y=%0d",
                   n_results, want.fire, want.target_index, want.target_x, want.target_y);
          $display("  got fire=%0d idx=%0d x=%0d y=%0d",
                   got.fire, got.target_index, got.target_x, got.target_y);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [5:0]  in_slot_index;
  logic        in_slot_active;
  coord_t      in_slot_x;
  coord_t      in_slot_y;
  coord_t      in_player_x;
  coord_t      in_player_y;
  logic [15:0] in_elapsed;
  logic        out_valid;
  logic        out_stall;
  logic        out_fire;
  logic [5:0]  out_target_index;
  coord_t      out_target_x;
  coord_t      out_target_y;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_cooldown;

  shot_scoreboard sb = new();

  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_left = 0;
  result_t      seen_shot;
  finder_item_t seen_item;

  nearest_target_cooldown_finder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .in_slot_active   (in_slot_active),
    .in_slot_x        (in_slot_x),
    .in_slot_y        (in_slot_y),
    .in_player_x      (in_player_x),
    .in_player_y      (in_player_y),
    .in_elapsed       (in_elapsed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fire         (out_fire),
    .out_target_index (out_target_index),
    .out_target_x     (out_target_x),
    .out_target_y     (out_target_y),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_cooldown     (cfg_cooldown)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // monitor: results first, then the input and cooldown transfers of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_shot.fire         = out_fire;
        seen_shot.target_index = out_target_index;
        seen_shot.target_x     = out_target_x;
        seen_shot.target_y     = out_target_y;
        sb.check_shot(seen_shot);
      end
      if (in_valid && !in_stall) begin
        seen_item.kind     = in_kind;
        seen_item.slot     = in_slot_index;
        seen_item.active   = in_slot_active;
        seen_item.slot_x   = in_slot_x;
        seen_item.slot_y   = in_slot_y;
        seen_item.player_x = in_player_x;
        seen_item.player_y = in_player_y;
        seen_item.elapsed  = in_elapsed;
        sb.take_item(seen_item);
      end
      if (cfg_valid && cfg_ready)
        sb.set_cooldown(cfg_cooldown);
    end
  end

  // receiver: random stall, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic finder_item_t mk_write(logic [5:0] slot, logic active, coord_t x, coord_t y);
    finder_item_t it;
    it.kind     = KIND_WRITE;
    it.slot     = slot;
    it.active   = active;
    it.slot_x   = x;
    it.slot_y   = y;
    it.player_x = coord_t'($urandom);
    it.player_y = coord_t'($urandom);
    it.elapsed  = 16'($urandom);
    return it;
  endfunction

  function automatic finder_item_t mk_tick(coord_t px, coord_t py, logic [15:0] elapsed);
    finder_item_t it;
    it.kind     = KIND_TICK;
    it.slot     = 6'($urandom);
    it.active   = 1'($urandom);
    it.slot_x   = coord_t'($urandom);
    it.slot_y   = coord_t'($urandom);
    it.player_x = px;
    it.player_y = py;
    it.elapsed  = elapsed;
    return it;
  endfunction

  // coordinates: extremes, a tight cluster that makes ties likely, or anything
  function automatic coord_t pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0:       return coord_t'(-32768);
        1:       return coord_t'(32767);
        2:       return coord_t'(-32767);
        default: return coord_t'(0);
      endcase
    end
    if (r < 50)
      return coord_t'(int'($urandom_range(16)) - 8);
    return coord_t'($urandom);
  endfunction

  function automatic finder_item_t random_item();
    int unsigned r;
    logic [5:0]  slot;
    logic [15:0] elapsed;
    if ($urandom_range(99) < 45) begin
      r = $urandom_range(99);
      if (r < 50)
        slot = 6'($urandom_range(7));
      else if (r < 60)
        slot = $urandom_range(1) ? 6'd63 : 6'd0;
      else
        slot = 6'($urandom_range(63));
      return mk_write(slot, $urandom_range(99) < 70, pick_coord(), pick_coord());
    end
    // elapsed spread around the current cooldown
    r = $urandom_range(99);
    if (r < 10)
      elapsed = '0;
    else if (r < 20)
      elapsed = 16'hffff;
    else if (r < 60)
      elapsed = 16'($urandom_range(sb.cooldown));
    else
      elapsed = 16'($urandom);
    return mk_tick(pick_coord(), pick_coord(), elapsed);
  endfunction

  // offer one item, with random gaps, and wait for its transfer
  task automatic send_item(input finder_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_slot_index  <= it.slot;
    in_slot_active <= it.active;
    in_slot_x      <= it.slot_x;
    in_slot_y      <= it.slot_y;
    in_player_x    <= it.player_x;
    in_player_y    <= it.player_y;
    in_elapsed     <= it.elapsed;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for the block to drain, then write the cooldown
  task automatic write_cooldown(input logic [15:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_cooldown <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [15:0] phase_cooldown [PHASES];
    int          phase_send [PHASES];
    int          phase_recv [PHASES];
    int          phase_items [PHASES];
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_slot_index  = '0;
    in_slot_active = 1'b0;
    in_slot_x      = '0;
    in_slot_y      = '0;
    in_player_x    = '0;
    in_player_y    = '0;
    in_elapsed     = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_cooldown   = '0;

    phase_cooldown = '{COOLDOWN_RESET, 16'd0, 16'hffff, 16'($urandom_range(2, 4000)),
                       16'd1, 16'($urandom_range(2, 4000))};
    phase_send  = '{23, 23, 86, 86, 0, 0};
    phase_recv  = '{86, 86, 23, 23, 0, 0};
    phase_items = '{320, 320, 300, 320, 300, 300};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: saturation, empty search, ties, threshold edge, deactivation
    send_item(mk_tick(16'sd0, 16'sd0, 16'd0));
    send_item(mk_tick(16'sd0, 16'sd0, 16'hffff));
    send_item(mk_tick(16'sd5, -16'sd5, 16'hffff));
    send_item(mk_write(6'd0, 1'b1, coord_t'(-32768), coord_t'(-32768)));
    send_item(mk_write(6'd63, 1'b1, coord_t'(32767), coord_t'(32767)));
    send_item(mk_write(6'd5, 1'b1, coord_t'(32767), coord_t'(32767)));
    send_item(mk_write(6'd10, 1'b0, 16'sd1, 16'sd1));
    send_item(mk_tick(coord_t'(32767), coord_t'(32767), 16'd0));
    send_item(mk_tick(16'sd1, 16'sd1, 16'd999));
    send_item(mk_tick(16'sd1, 16'sd1, 16'd1));
    send_item(mk_write(6'd5, 1'b0, 16'sd0, 16'sd0));
    send_item(mk_tick(coord_t'(32767), coord_t'(-32768), 16'hffff));
    send_item(mk_tick(coord_t'(-32768), coord_t'(32767), 16'hffff));
    send_item(mk_write(6'd0, 1'b0, 16'sd0, 16'sd0));
    send_item(mk_write(6'd63, 1'b0, 16'sd0, 16'sd0));
    send_item(mk_tick(16'sd0, 16'sd0, 16'hffff));
    send_item(mk_write(6'd42, 1'b1, -16'sd5, 16'sd7));
    send_item(mk_tick(16'sd0, 16'sd0, 16'd0));
    // zero cooldown searches on every tick
    write_cooldown(16'd0);
    send_item(mk_tick(16'sd100, -16'sd100, 16'd0));
    send_item(mk_write(6'd42, 1'b0, 16'sd3, 16'sd3));
    send_item(mk_tick(16'sd0, 16'sd0, 16'd0));

    // random phases over cooldown settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      write_cooldown(phase_cooldown[p]);
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      if (p == 4)
        hold_left = HOLD_CYCLES;
      if (p == 5)
        for (int s = 0; s < SLOT_COUNT; s++)
          send_item(mk_write(6'(s), 1'b0, pick_coord(), pick_coord()));
      for (int k = 0; k < phase_items[p]; k++)
        send_item(random_item());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d ticks), %0d shots fired, %0d results checked",
             sb.n_items, sb.n_ticks, sb.n_fires, sb.n_results);
    $display("cooldowns 1000, 0, 1, 65535 and random; %0d mismatches in %0d cycles",
             sb.n_errors, cycle_count);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
